### rtl/text_console_writer_core_assert.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms for the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMP(NAME, CLK, RSTN, ANT, CON, MSG) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error(MSG);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NXT(NAME, CLK, RSTN, ANT, CON, MSG) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Field widths, command codes, character codes and sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CMD_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CELL_W  = 16;
    localparam int COLOR_W = 8;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    localparam int TAB_STOP = 8;

    localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_ROW,
        S_CLEAR,
        S_SCR_RD,
        S_SCR_WR,
        S_SCR_BLK,
        S_READ,
        S_DONE
    } t_state;

endpackage

### rtl/tcw_add_cmp.sv
// ----------------------------------------------------------------------------
// Shared add and compare unit
// Adds two operands and tells whether the sum lies below a limit.
// ----------------------------------------------------------------------------
module tcw_add_cmp #(
    parameter int W = 13
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_lim,
    output logic [W-1:0] o_sum,
    output logic         o_lt
);

    assign o_sum = i_a + i_b;
    assign o_lt  = (o_sum < i_lim);

endmodule

### rtl/tcw_screen_ram.sv
// ----------------------------------------------------------------------------
// Screen cell memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// Text console writer core
// A ROWS x COLUMNS screen of 16-bit cells with a cursor, driven by put-char,
// clear and read-cell commands through a small sequencer and one shared
// add and compare unit.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_ready   | command, char_code, cell_index
//  out     | source    | o_out_valid / i_out_ready | cursor_row, cursor_col,
//          |           |                           | cell_data, scrolled
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | text_color
//
// An input beat passes through S_EXEC and S_DONE for carriage return, an
// ordinary character without wrap and the unused command; a newline or a
// wrap also passes through S_ROW, and a read of a cell on the screen through
// S_READ for the registered memory port. A scroll copies every cell below
// the top row up one row, each copy needing one read and one write on the
// single-port-each memory, finds the end of the copy in S_SCR_RD and then
// blanks the bottom row. A clear writes every cell, one cell write per cycle.
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells that
// writes the blank cell 0x0720 everywhere; no input beat is taken meanwhile,
// but configuration beats are. The result sits in an output register, so the
// next input beat may be taken while the previous result is still stalled.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcw_pkg::CMD_W-1:0]     i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   i_cell_index,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_col,
    output logic [tcw_pkg::CELL_W-1:0]    o_cell_data,
    output logic                          o_scrolled,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_cfg_text_color
);

`include "text_console_writer_core_assert.svh"

    // Screen geometry and derived widths.
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int AW      = $clog2(CELLS);
    localparam int RW      = $clog2(ROWS);
    localparam int CW      = $clog2(COLUMNS);
    localparam int SW0     = $clog2(CELLS + COLUMNS + 1);
    localparam int SW      = ((SW0 > tcw_pkg::INDEX_W) ? SW0 : tcw_pkg::INDEX_W) + 1;
    localparam int OUT_RW  = tcw_pkg::ROW_W;
    localparam int OUT_CW  = tcw_pkg::COL_W;

    // Sequencer and cursor state.
    tcw_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_cnt,   n_cnt;
    logic [RW-1:0]   r_row,   n_row;
    logic [CW-1:0]   r_col,   n_col;

    // The blank or fill value used by the current sweep.
    logic [tcw_pkg::CELL_W-1:0]  r_fill, n_fill;
    logic [tcw_pkg::COLOR_W-1:0] r_color;

    // Captured input beat and result being built.
    logic [tcw_pkg::CMD_W-1:0]   r_cmd,  n_cmd;
    logic [tcw_pkg::CHAR_W-1:0]  r_char, n_char;
    logic [tcw_pkg::INDEX_W-1:0] r_idx,  n_idx;
    logic [tcw_pkg::CELL_W-1:0]  r_data, n_data;
    logic                        r_scr,  n_scr;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic [OUT_RW-1:0]           r_out_row,   n_out_row;
    logic [OUT_CW-1:0]           r_out_col,   n_out_col;
    logic [tcw_pkg::CELL_W-1:0]  r_out_data,  n_out_data;
    logic                        r_out_scr,   n_out_scr;

    // Shared unit and memory port controls.
    logic [SW-1:0]               alu_a, alu_b, alu_lim, alu_sum;
    logic                        alu_lt;
    logic                        mem_we, mem_re;
    logic [AW-1:0]               mem_waddr, mem_raddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_wdata, mem_rdata;

    logic [AW-1:0]               cursor_addr;
    logic [tcw_pkg::CELL_W-1:0]  blank_cell;
    logic                        in_beat;

    // Linear address of the cursor; the cursor is always on the screen.
    assign cursor_addr = AW'(AW'(r_row) * AW'(COLUMNS)) + AW'(r_col);
    assign blank_cell  = {r_color, tcw_pkg::CH_SPACE};
    assign in_beat     = i_in_valid && o_in_ready;

    tcw_add_cmp #(
        .W (SW)
    ) u_add_cmp (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_lim (alu_lim),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The color register takes a beat in any cycle; the user, not the block, must
    // issue writes only while no command is in flight, so no sweep sees it change.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == tcw_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_INIT;
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_fill      <= tcw_pkg::RESET_CELL;
            r_color     <= tcw_pkg::RESET_COLOR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_row       <= n_row;
            r_col       <= n_col;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_color <= i_cfg_text_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_char     <= n_char;
        r_idx      <= n_idx;
        r_data     <= n_data;
        r_scr      <= n_scr;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_data <= n_out_data;
        r_out_scr  <= n_out_scr;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_fill      = r_fill;
        n_cmd       = r_cmd;
        n_char      = r_char;
        n_idx       = r_idx;
        n_data      = r_data;
        n_scr       = r_scr;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_data  = r_out_data;
        n_out_scr   = r_out_scr;
        n_out_valid = r_out_valid && !i_out_ready;

        alu_a       = '0;
        alu_b       = '0;
        alu_lim     = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_cnt;
        mem_wdata   = r_fill;
        mem_re      = 1'b0;
        mem_raddr   = r_cnt;

        case (r_state)
            // The reset pass and the clear command both fill every cell
            // with r_fill, one cell per cycle.
            tcw_pkg::S_INIT,
            tcw_pkg::S_CLEAR: begin
                mem_we  = 1'b1;
                alu_a   = SW'(r_cnt);
                alu_b   = SW'(1);
                alu_lim = SW'(CELLS);
                if (alu_lt) begin
                    n_cnt = AW'(alu_sum);
                end else if (r_state == tcw_pkg::S_INIT) begin
                    n_state = tcw_pkg::S_IDLE;
                end else begin
                    n_state = tcw_pkg::S_DONE;
                end
            end

            tcw_pkg::S_IDLE: begin
                if (in_beat) begin
                    n_cmd   = i_command;
                    n_char  = i_char_code;
                    n_idx   = i_cell_index;
                    n_data  = '0;
                    n_scr   = 1'b0;
                    n_state = tcw_pkg::S_EXEC;
                end
            end

            tcw_pkg::S_EXEC: begin
                case (r_cmd)
                    tcw_pkg::CMD_PUT: begin
                        if (r_char == tcw_pkg::CH_NEWLINE) begin
                            n_col   = '0;
                            n_state = tcw_pkg::S_ROW;
                        end else if (r_char == tcw_pkg::CH_RETURN) begin
                            n_col   = '0;
                            n_state = tcw_pkg::S_DONE;
                        end else begin
                            // Tab rounds down to a stop and adds one stop;
                            // any other byte is stored and steps one column.
                            if (r_char == tcw_pkg::CH_TAB) begin
                                alu_a = SW'(r_col & ~CW'(tcw_pkg::TAB_STOP - 1));
                                alu_b = SW'(tcw_pkg::TAB_STOP);
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_addr;
                                mem_wdata = {r_color, r_char};
                                alu_a     = SW'(r_col);
                                alu_b     = SW'(1);
                            end
                            alu_lim = SW'(COLUMNS);
                            if (alu_lt) begin
                                n_col   = CW'(alu_sum);
                                n_state = tcw_pkg::S_DONE;
                            end else begin
                                n_col   = '0;
                                n_state = tcw_pkg::S_ROW;
                            end
                        end
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        n_fill  = blank_cell;
                        n_cnt   = '0;
                        n_row   = '0;
                        n_col   = '0;
                        n_state = tcw_pkg::S_CLEAR;
                    end
                    tcw_pkg::CMD_READ: begin
                        alu_a   = SW'(r_idx);
                        alu_b   = '0;
                        alu_lim = SW'(CELLS);
                        if (alu_lt) begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(r_idx);
                            n_state   = tcw_pkg::S_READ;
                        end else begin
                            n_state = tcw_pkg::S_DONE;
                        end
                    end
                    default: begin
                        n_state = tcw_pkg::S_DONE;
                    end
                endcase
            end

            // Step to the next row; running off the bottom starts a scroll.
            tcw_pkg::S_ROW: begin
                alu_a   = SW'(r_row);
                alu_b   = SW'(1);
                alu_lim = SW'(ROWS);
                if (alu_lt) begin
                    n_row   = RW'(alu_sum);
                    n_state = tcw_pkg::S_DONE;
                end else begin
                    n_row   = RW'(ROWS - 1);
                    n_scr   = 1'b1;
                    n_fill  = blank_cell;
                    n_cnt   = '0;
                    n_state = tcw_pkg::S_SCR_RD;
                end
            end

            // Fetch the cell one row below the destination, if there is one.
            tcw_pkg::S_SCR_RD: begin
                alu_a   = SW'(r_cnt);
                alu_b   = SW'(COLUMNS);
                alu_lim = SW'(CELLS);
                if (alu_lt) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(alu_sum);
                    n_state   = tcw_pkg::S_SCR_WR;
                end else begin
                    n_state = tcw_pkg::S_SCR_BLK;
                end
            end

            tcw_pkg::S_SCR_WR: begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                alu_a     = SW'(r_cnt);
                alu_b     = SW'(1);
                alu_lim   = SW'(CELLS);
                n_cnt     = AW'(alu_sum);
                n_state   = tcw_pkg::S_SCR_RD;
            end

            // Blank the bottom row with the current color.
            tcw_pkg::S_SCR_BLK: begin
                mem_we  = 1'b1;
                alu_a   = SW'(r_cnt);
                alu_b   = SW'(1);
                alu_lim = SW'(CELLS);
                if (alu_lt) begin
                    n_cnt = AW'(alu_sum);
                end else begin
                    n_state = tcw_pkg::S_DONE;
                end
            end

            tcw_pkg::S_READ: begin
                n_data  = mem_rdata;
                n_state = tcw_pkg::S_DONE;
            end

            // Hand the result to the output register once it is free.
            tcw_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_row   = OUT_RW'(r_row);
                    n_out_col   = OUT_CW'(r_col);
                    n_out_data  = r_data;
                    n_out_scr   = r_scr;
                    n_state     = tcw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tcw_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_cell_data  = r_out_data;
    assign o_scrolled   = r_out_scr;

    // The cursor never leaves the screen.
    `TCW_ASSERT_IMP(a_cursor_range, i_clk, i_rst_n, 1'b1, (int'(r_row) < ROWS) && (int'(r_col) < COLUMNS), "cursor left the screen")

    // A scrolled result always leaves the cursor at the start of the last row.
    `TCW_ASSERT_IMP(a_scroll_cursor, i_clk, i_rst_n, o_out_valid && o_scrolled, (o_cursor_row == OUT_RW'(ROWS - 1)) && (o_cursor_col == '0), "scroll left cursor misplaced")

    // The memory is never written while the block waits for a command.
    `TCW_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == tcw_pkg::S_IDLE, !mem_we, "memory written while idle")

    // A finished command whose result slot is free shows a result next cycle.
    `TCW_ASSERT_NXT(a_done_loads, i_clk, i_rst_n, (r_state == tcw_pkg::S_DONE) && (!r_out_valid || i_out_ready), o_out_valid && (r_state == tcw_pkg::S_IDLE), "result not loaded")

endmodule

### dv/tb_text_console_writer_core.sv
// ----------------------------------------------------------------------------
// Text console writer core testbench
// Drives put, clear, read and unused commands into the console core, keeps
// its own copy of the screen, cursor and color, and checks every result beat
// field by field. Both channels idle and stall in random bursts, and the
// color register is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_text_console_writer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int NUM_COLS  = 80;
    localparam int NUM_ROWS  = 25;
    localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;
    localparam int INDEX_MAX = (1 << INDEX_W) - 1;

    // The command code that the core leaves unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // A scroll is the slowest command, slower even than the clearing pass after
    // reset. The watchdog limit covers either several times over, together with
    // the longest receiver stall.
    localparam int IDLE_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 4200;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [CELL_W-1:0] data;
        logic              scrolled;
    } t_console_status;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [CMD_W-1:0]     i_command;
    logic [CHAR_W-1:0]    i_char_code;
    logic [INDEX_W-1:0]   i_cell_index;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [ROW_W-1:0]     o_cursor_row;
    logic [COL_W-1:0]     o_cursor_col;
    logic [CELL_W-1:0]    o_cell_data;
    logic                 o_scrolled;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [COLOR_W-1:0]   i_cfg_text_color;

    // Our own picture of the console: every cell, the cursor and the color.
    logic [CELL_W-1:0]    screen_image [NUM_CELLS];
    int unsigned          cur_row;
    int unsigned          cur_col;
    logic [COLOR_W-1:0]   attr_color;

    // Cursor and cell results still owed by the core, oldest first.
    t_console_status      pending_status [$];

    int error_count;
    int results_seen;
    int scrolls_seen;
    int commands_sent;
    int reads_sent;
    int clears_sent;
    int color_writes;
    int stuck_cycles;

    // Knobs shared by the tests, the command sender and the receiver process.
    bit in_gaps_on;
    bit out_stalls_on;
    int hold_left;

    text_console_writer_core #(
        .COLUMNS (NUM_COLS),
        .ROWS    (NUM_ROWS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_command        (i_command),
        .i_char_code      (i_char_code),
        .i_cell_index     (i_cell_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_col     (o_cursor_col),
        .o_cell_data      (o_cell_data),
        .o_scrolled       (o_scrolled),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_text_color (i_cfg_text_color)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Screen predictor
    // ------------------------------------------------------------------------

    function automatic void blank_screen(logic [CELL_W-1:0] fill_value);
        foreach (screen_image[i]) screen_image[i] = fill_value;
    endfunction

    // Moves the cursor down one row. Past the last row the whole screen moves
    // up one line and the bottom line is blanked in the current color.
    function automatic bit next_line();
        cur_row++;
        if (cur_row < NUM_ROWS) return 1'b0;
        for (int i = 0; i < NUM_CELLS - NUM_COLS; i++)
            screen_image[i] = screen_image[i + NUM_COLS];
        for (int i = NUM_CELLS - NUM_COLS; i < NUM_CELLS; i++)
            screen_image[i] = {attr_color, CH_SPACE};
        cur_row = NUM_ROWS - 1;
        return 1'b1;
    endfunction

    // Applies one accepted command to the picture and returns the result
    // beat that the core must produce for it.
    function automatic t_console_status apply_console_command(
        logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
        t_console_status st;
        bit              moved_up;
        st       = '0;
        moved_up = 1'b0;
        case (cmd)
            CMD_PUT: begin
                if (ch == CH_NEWLINE) begin
                    cur_col  = 0;
                    moved_up = next_line();
                end else if (ch == CH_RETURN) begin
                    cur_col = 0;
                end else if (ch == CH_TAB) begin
                    // Round up to the next tab stop; a stop at or past the
                    // line end wraps to the start of the next row.
                    cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
                    if (cur_col >= NUM_COLS) begin
                        cur_col  = 0;
                        moved_up = next_line();
                    end
                end else begin
                    screen_image[cur_row * NUM_COLS + cur_col] = {attr_color, ch};
                    cur_col++;
                    if (cur_col >= NUM_COLS) begin
                        cur_col  = 0;
                        moved_up = next_line();
                    end
                end
            end
            CMD_CLEAR: begin
                // Clear uses the color in force now, not the reset color.
                blank_screen({attr_color, CH_SPACE});
                cur_row = 0;
                cur_col = 0;
            end
            CMD_READ: begin
                // Indexes past the screen read back as zero.
                if (idx < NUM_CELLS) st.data = screen_image[idx];
            end
            default: ;
        endcase
        st.row      = cur_row[ROW_W-1:0];
        st.col      = cur_col[COL_W-1:0];
        st.scrolled = moved_up;
        return st;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what);
        error_count++;
        $display("[%0t] MISMATCH at result %0d: %s", $time, results_seen, what);
    endtask

    task automatic check_field(string name, logic [CELL_W-1:0] got,
                               logic [CELL_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Every result beat is matched against the oldest outstanding command.
    always @(posedge i_clk) begin
        t_console_status want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result beat with no command outstanding");
            end else begin
                want = pending_status.pop_front();
                results_seen++;
                if (want.scrolled) scrolls_seen++;
                check_field("cursor_row", CELL_W'(o_cursor_row), CELL_W'(want.row));
                check_field("cursor_col", CELL_W'(o_cursor_col), CELL_W'(want.col));
                check_field("cell_data", o_cell_data, want.data);
                check_field("scrolled", CELL_W'(o_scrolled), CELL_W'(want.scrolled));
            end
        end
    end

    // The watchdog only looks at progress: any beat on any channel resets it.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat on any channel for %0d cycles, %0d results owed",
                     IDLE_LIMIT, pending_status.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver side. A long hold set by a test takes priority; otherwise
    // ready drops in random bursts while stalls are enabled.
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else if (out_stalls_on && $urandom_range(0, 7) == 0) begin
                i_out_ready = 1'b0;
                stall_left  = int'($urandom_range(1, 14)) - 1;
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Sends one command beat, sometimes after a burst of idle cycles. Valid
    // stays high after the beat so that back-to-back calls stream without a
    // bubble; anything that waits must drop it first.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                logic [INDEX_W-1:0] idx);
        int gap;
        if (in_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = int'($urandom_range(1, 14));
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_command    = cmd;
        i_char_code  = ch;
        i_cell_index = idx;
        do @(posedge i_clk); while (!o_in_ready);
        pending_status.push_back(apply_console_command(cmd, ch, idx));
        commands_sent++;
        if (cmd == CMD_READ) reads_sent++;
        if (cmd == CMD_CLEAR) clears_sent++;
    endtask

    // Stops offering commands and waits until every owed result has arrived.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
    endtask

    // The color register is only written once the core has gone idle.
    task automatic write_text_color(logic [COLOR_W-1:0] value);
        wait_for_drain();
        @(negedge i_clk);
        i_cfg_valid      = 1'b1;
        i_cfg_text_color = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        attr_color = value;
        color_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One command drawn from a mix that looks like terminal traffic: mostly
    // text with line breaks, so the cursor reaches the bottom and the screen
    // scrolls, plus reads aimed near the cursor where cells have just changed,
    // and a little noise: stray reads, rare clears and the unused code.
    task automatic send_random_command();
        int                 pick;
        int unsigned        near_row;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        pick = int'($urandom_range(0, 999));
        ch   = CHAR_W'($urandom_range(0, 255));
        idx  = INDEX_W'($urandom_range(0, INDEX_MAX));
        if (pick < 560) begin
            ch = CHAR_W'($urandom_range(33, 126));
            send_command(CMD_PUT, ch, idx);
        end else if (pick < 660) begin
            send_command(CMD_PUT, ch, idx);
        end else if (pick < 760) begin
            send_command(CMD_PUT, CH_NEWLINE, idx);
        end else if (pick < 800) begin
            send_command(CMD_PUT, CH_TAB, idx);
        end else if (pick < 830) begin
            send_command(CMD_PUT, CH_RETURN, idx);
        end else if (pick < 930) begin
            near_row = (cur_row == 0 || $urandom_range(0, 1) == 0) ? cur_row : cur_row - 1;
            idx = INDEX_W'(near_row * NUM_COLS + $urandom_range(0, NUM_COLS - 1));
            send_command(CMD_READ, ch, idx);
        end else if (pick < 985) begin
            send_command(CMD_READ, ch, idx);
        end else if (pick < 988) begin
            send_command(CMD_CLEAR, ch, idx);
        end else begin
            send_command(CMD_UNUSED, ch, idx);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Straight out of reset: the blank screen, reads past the end, the unused
    // code and a character in the reset color.
    task automatic test_reset_defaults();
        send_command(CMD_READ, 8'h00, 11'd0);
        send_command(CMD_READ, 8'hFF, INDEX_W'(NUM_CELLS - 1));
        send_command(CMD_READ, 8'h00, INDEX_W'(NUM_CELLS));
        send_command(CMD_READ, 8'h00, INDEX_W'(INDEX_MAX));
        send_command(CMD_UNUSED, 8'hFF, INDEX_W'(INDEX_MAX));
        send_command(CMD_PUT, 8'h41, 11'd0);
        send_command(CMD_READ, 8'h00, 11'd0);
    endtask

    // Extreme character bytes, carriage return, newline, and a run of tabs
    // whose last one wraps at the line end.
    task automatic test_control_codes();
        write_text_color(8'h00);
        send_command(CMD_PUT, 8'h00, 11'd0);
        send_command(CMD_PUT, 8'hFF, 11'd0);
        send_command(CMD_READ, 8'h00, 11'd1);
        send_command(CMD_READ, 8'h00, 11'd2);
        send_command(CMD_PUT, CH_RETURN, 11'd0);
        send_command(CMD_PUT, CH_NEWLINE, 11'd0);
        repeat (NUM_COLS / TAB_STOP) send_command(CMD_PUT, CH_TAB, 11'd0);
    endtask

    // Clear must paint the screen in the color written last.
    task automatic test_clear_color();
        write_text_color(8'hFF);
        send_command(CMD_CLEAR, 8'h00, 11'd0);
        send_command(CMD_READ, 8'h00, INDEX_W'($urandom_range(0, NUM_CELLS - 1)));
    endtask

    // The receiver holds off long enough for the core to fill up and stall
    // its input while commands keep coming; then the sender waits for all
    // results before going on.
    task automatic test_output_hold();
        logic [CHAR_W-1:0] ch;
        wait_for_drain();
        hold_left = HOLD_CYCLES;
        repeat (16) begin
            ch = CHAR_W'($urandom_range(33, 126));
            send_command(CMD_PUT, ch, 11'd0);
        end
        wait_for_drain();
    endtask

    // Several phases of terminal-like traffic, each in a fresh random color
    // and with its own mix of idling on the two sides.
    task automatic test_random_text();
        repeat (6) begin
            write_text_color(COLOR_W'($urandom_range(0, 255)));
            in_gaps_on    = ($urandom_range(0, 2) != 0);
            out_stalls_on = ($urandom_range(0, 2) != 0);
            repeat (260) send_random_command();
        end
    endtask

    // The last stretch runs with no idling on either side.
    task automatic test_steady_stream();
        write_text_color(COLOR_W'($urandom_range(0, 255)));
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        repeat (300) send_random_command();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_command        = CMD_PUT;
        i_char_code      = '0;
        i_cell_index     = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_text_color = RESET_COLOR;
        in_gaps_on       = 1'b1;
        out_stalls_on    = 1'b1;
        hold_left        = 0;
        error_count      = 0;
        results_seen     = 0;
        scrolls_seen     = 0;
        commands_sent    = 0;
        reads_sent       = 0;
        clears_sent      = 0;
        color_writes     = 0;
        stuck_cycles     = 0;

        // The predictor starts where the core does after reset.
        attr_color = RESET_COLOR;
        cur_row    = 0;
        cur_col    = 0;
        blank_screen(RESET_CELL);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_control_codes();
        test_clear_color();
        test_output_hold();
        test_random_text();
        test_steady_stream();

        // Let any stray beat show up before judging the run.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d commands: %0d reads, %0d clears, %0d scrolls checked",
                 commands_sent, reads_sent, clears_sent, scrolls_seen);
        $display("%0d results compared over %0d color settings, %0d mismatches",
                 results_seen, color_writes + 1, error_count);
        if (error_count == 0 && pending_status.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### text_console_writer_core.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_add_cmp.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer_core.sv
dv/tb_text_console_writer_core.sv
